// File: hdl/bos_pkg.sv
`default_nettype none

package bos_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;

  localparam int QUARTER_LEN = 1 << SINE_TABLE_BITS;
  localparam int ROM_ADDR_W  = SINE_TABLE_BITS + 1;
  localparam int SINE_W      = 15;

  localparam int ACTION_W  = 1;
  localparam int HR_W      = 12;
  localparam int HRV_W     = 12;
  localparam int SAMPLE_W  = 16;
  localparam int FREQ_W    = 18;
  localparam int GAIN_W    = 16;
  localparam int ALPHA_W   = 16;
  localparam int PER_HZ_W  = 26;
  localparam int TARGET_W  = 18;
  localparam int GNUM_W    = 21;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 26;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAPPING_ENABLED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING_ALPHA = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_PER_HZ     = 2'd2;

  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd6554;
  localparam logic [PER_HZ_W-1:0] PER_HZ_RESET = 26'd22906492;
  localparam logic [FREQ_W-1:0]   FREQ_RESET   = 18'd56320;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd16384;

  localparam logic [ACTION_W-1:0] ACTION_UPDATE = 1'b0;
  localparam logic [ACTION_W-1:0] ACTION_SAMPLE = 1'b1;

  // heart rate and HRV mapping, 1/16 units
  localparam logic [HR_W-1:0]     HR_MIN      = 12'd640;
  localparam logic [HR_W-1:0]     HR_MAX      = 12'd3200;
  localparam logic [HRV_W-1:0]    HRV_MAX     = 12'd1600;
  localparam logic [TARGET_W-1:0] TARGET_BASE = 18'd25600;
  localparam logic [GNUM_W-1:0]   GNUM_BASE   = 21'd409662;
  // reciprocal of 125, scaled by 2^28, exact for 21-bit numerators
  localparam int                  GAIN_RECIP       = 2147484;
  localparam int                  GAIN_RECIP_SHIFT = 28;

  // shared multiplier operand widths
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 23;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // phase step rounding
  localparam int STEP_SHIFT = 48 - PHASE_BITS;
  localparam int STEP_SUM_W = 49;
  localparam logic [STEP_SUM_W-1:0] STEP_ROUND =
    (STEP_SHIFT == 0) ? '0 : (49'd1 << (STEP_SHIFT - 1));
  localparam logic [STEP_SUM_W-1:0] STEP_RESET_SUM =
    STEP_SUM_W'(FREQ_RESET) * STEP_SUM_W'(PER_HZ_RESET) + STEP_ROUND;
  localparam logic [PHASE_BITS-1:0] STEP_RESET = STEP_RESET_SUM[STEP_SHIFT +: PHASE_BITS];

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // series divisors (2k)(2k+1) as reciprocals scaled by 2^42, exact below 2^33
  localparam int SERIES_RECIP_SHIFT = 42;

  typedef logic [2:0] pc_t;

  localparam pc_t PC_U_SMOOTH = 3'd0;
  localparam pc_t PC_U_FREQ   = 3'd1;
  localparam pc_t PC_U_GAIN   = 3'd2;
  localparam pc_t PC_U_STEP   = 3'd3;
  localparam pc_t PC_S_READ   = 3'd4;
  localparam pc_t PC_S_MUL    = 3'd5;
  localparam pc_t PC_S_OUT    = 3'd6;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SMOOTH,
    MUL_GAIN,
    MUL_STEP,
    MUL_SINE
  } mul_sel_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_FREQ,
    WB_GAIN,
    WB_STEP,
    WB_SAMPLE
  } wb_sel_t;

  typedef enum logic [1:0] {
    FLOW_NEXT,
    FLOW_END,
    FLOW_END_IF_OFF
  } flow_t;

  typedef struct packed {
    mul_sel_t mul;
    wb_sel_t  wb;
    flow_t    flow;
  } ucode_t;

  typedef struct packed {
    logic mapping_enabled;
    logic out_free;
  } dp_status_t;

  localparam ucode_t UCODE_IDLE = '{mul: MUL_NONE, wb: WB_NONE, flow: FLOW_END};

  // control store: each write-back consumes the product of the step before
  function automatic ucode_t ucode_word(input pc_t pc);
    ucode_t w;
    w = UCODE_IDLE;
    case (pc)
      PC_U_SMOOTH: w = '{mul: MUL_SMOOTH, wb: WB_NONE,   flow: FLOW_END_IF_OFF};
      PC_U_FREQ:   w = '{mul: MUL_GAIN,   wb: WB_FREQ,   flow: FLOW_NEXT};
      PC_U_GAIN:   w = '{mul: MUL_STEP,   wb: WB_GAIN,   flow: FLOW_NEXT};
      PC_U_STEP:   w = '{mul: MUL_NONE,   wb: WB_STEP,   flow: FLOW_END};
      PC_S_READ:   w = '{mul: MUL_NONE,   wb: WB_NONE,   flow: FLOW_NEXT};
      PC_S_MUL:    w = '{mul: MUL_SINE,   wb: WB_NONE,   flow: FLOW_NEXT};
      PC_S_OUT:    w = '{mul: MUL_NONE,   wb: WB_SAMPLE, flow: FLOW_END};
      default:     w = UCODE_IDLE;
    endcase
    return w;
  endfunction

  // quarter-wave sine entry, unsigned Q0.15 with full scale 32767; elaboration only
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [31:0] i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    logic [63:0]        recip;
    logic [127:0]       quot;
    x   = (PI_HALF_Q30 * 64'(i)) >> SINE_TABLE_BITS;
    x2  = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int k = 1; k <= 8; k++) begin
      case (k)
        1:       recip = 64'd733007751851;
        2:       recip = 64'd219902325556;
        3:       recip = 64'd104715393122;
        4:       recip = 64'd61083979321;
        5:       recip = 64'd39982241011;
        6:       recip = 64'd28192605841;
        7:       recip = 64'd20943078625;
        default: recip = 64'd16169288644;
      endcase
      quot = (128'((term * x2) >> 30) * 128'(recip)) >> SERIES_RECIP_SHIFT;
      term = quot[63:0];
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/bos_ifs.sv
`default_nettype none

interface bos_in_if;
  import bos_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [HR_W-1:0]     heart_rate;
  logic [HRV_W-1:0]    hrv_level;
  modport source (output valid, output action, output heart_rate, output hrv_level,
                  input ready);
  modport sink   (input valid, input action, input heart_rate, input hrv_level,
                  output ready);
endinterface

interface bos_out_if;
  import bos_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: hdl/bos_sine_rom.sv
`default_nettype none

module bos_sine_rom (
  input  wire logic                           clk,
  input  wire logic [bos_pkg::ROM_ADDR_W-1:0] addr,
  output logic      [bos_pkg::SINE_W-1:0]     data_r
);
  import bos_pkg::*;

  logic [SINE_W-1:0] tab [0:QUARTER_LEN];

  for (genvar g = 0; g <= QUARTER_LEN; g++) begin : g_tab
    localparam logic [SINE_W-1:0] ENTRY = quarter_sine(32'(g));
    assign tab[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    data_r <= tab[addr];
  end

endmodule

`default_nettype wire

// File: hdl/bos_sequencer.sv
`default_nettype none

module bos_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [bos_pkg::ACTION_W-1:0]  action,
  input  wire bos_pkg::dp_status_t           status,
  output logic                               ready,
  output bos_pkg::ucode_t                    ctrl
);
  import bos_pkg::*;

  logic   busy_r;
  logic   busy_nxt;
  pc_t    pc_r;
  pc_t    pc_nxt;
  ucode_t word;
  logic   stall;

  assign word  = busy_r ? ucode_word(pc_r) : UCODE_IDLE;
  assign stall = (word.wb == WB_SAMPLE) && !status.out_free;
  assign ready = !busy_r;

  always_comb begin
    ctrl = word;
    if (stall) begin
      ctrl.wb = WB_NONE;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = (action == ACTION_SAMPLE) ? PC_S_READ : PC_U_SMOOTH;
    end else if (busy_r && !stall) begin
      case (word.flow)
        FLOW_NEXT: begin
          pc_nxt = pc_r + 3'd1;
        end
        FLOW_END: begin
          busy_nxt = 1'b0;
        end
        FLOW_END_IF_OFF: begin
          if (status.mapping_enabled) begin
            pc_nxt = pc_r + 3'd1;
          end else begin
            busy_nxt = 1'b0;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_U_SMOOTH;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bos_datapath.sv
`default_nettype none

module bos_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire bos_pkg::ucode_t                       ctrl,
  input  wire logic                                  accept,
  input  wire logic        [bos_pkg::HR_W-1:0]       heart_rate,
  input  wire logic        [bos_pkg::HRV_W-1:0]      hrv_level,
  input  wire logic        [bos_pkg::ALPHA_W-1:0]    alpha,
  input  wire logic        [bos_pkg::PER_HZ_W-1:0]   step_per_hz,
  input  wire logic        [bos_pkg::SINE_W-1:0]     rom_data,
  output logic             [bos_pkg::ROM_ADDR_W-1:0] rom_addr,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output logic signed      [bos_pkg::SAMPLE_W-1:0]   sample_out,
  output logic                                       out_free
);
  import bos_pkg::*;

  logic        [PHASE_BITS-1:0]      phase_r;
  logic        [PHASE_BITS-1:0]      phase_nxt;
  logic        [PHASE_BITS-1:0]      step_r;
  logic        [PHASE_BITS-1:0]      step_nxt;
  logic        [FREQ_W-1:0]          freq_r;
  logic        [FREQ_W-1:0]          freq_nxt;
  logic        [GAIN_W-1:0]          gain_r;
  logic        [GAIN_W-1:0]          gain_nxt;
  logic        [TARGET_W-1:0]        target_r;
  logic        [GNUM_W-1:0]          gnum_r;
  logic signed [PROD_W-1:0]          prod_r;
  logic signed [SAMPLE_W-1:0]        sample_r;
  logic signed [SAMPLE_W-1:0]        sample_nxt;
  logic                              out_valid_r;

  logic        [HR_W-1:0]            hr_clamp;
  logic        [HR_W-1:0]            hr_off;
  logic        [HRV_W-1:0]           hrv_clamp;
  logic        [TARGET_W-1:0]        target_nxt;
  logic        [GNUM_W-1:0]          gnum_nxt;

  logic signed [MUL_A_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]         mul_b;
  logic signed [FREQ_W:0]            freq_diff;
  logic signed [MUL_A_W-1:0]         sine_mag;
  logic signed [35:0]                freq_acc;
  logic        [STEP_SUM_W-1:0]      step_sum;
  logic signed [32:0]                samp_sum;

  logic        [1:0]                 quad;
  logic        [SINE_TABLE_BITS-1:0] pos;

  // request fields, clamped and mapped at acceptance
  always_comb begin
    hr_clamp = heart_rate;
    if (heart_rate < HR_MIN) begin
      hr_clamp = HR_MIN;
    end else if (heart_rate > HR_MAX) begin
      hr_clamp = HR_MAX;
    end
    hr_off     = hr_clamp - HR_MIN;
    target_nxt = TARGET_BASE + (TARGET_W'(hr_off) << 6) + (TARGET_W'(hr_off) << 2)
               + (TARGET_W'(hr_off) << 1);
    hrv_clamp  = (hrv_level > HRV_MAX) ? HRV_MAX : hrv_level;
    gnum_nxt   = (GNUM_W'(hrv_clamp) << 10) + GNUM_BASE;
  end

  // quarter-wave addressing
  assign quad     = phase_r[PHASE_BITS-1 -: 2];
  assign pos      = phase_r[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? (ROM_ADDR_W'(QUARTER_LEN) - {1'b0, pos}) : {1'b0, pos};

  // shared multiplier operand select
  assign freq_diff = $signed({1'b0, target_r}) - $signed({1'b0, freq_r});
  assign sine_mag  = $signed({{(MUL_A_W - SINE_W){1'b0}}, rom_data});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      MUL_SMOOTH: begin
        mul_a = MUL_A_W'(freq_diff);
        mul_b = $signed({{(MUL_B_W - ALPHA_W){1'b0}}, alpha});
      end
      MUL_GAIN: begin
        mul_a = MUL_A_W'(GAIN_RECIP);
        mul_b = $signed({{(MUL_B_W - GNUM_W){1'b0}}, gnum_r});
      end
      MUL_STEP: begin
        mul_a = $signed({{(MUL_A_W - PER_HZ_W){1'b0}}, step_per_hz});
        mul_b = $signed({{(MUL_B_W - FREQ_W){1'b0}}, freq_r});
      end
      MUL_SINE: begin
        mul_a = quad[1] ? -sine_mag : sine_mag;
        mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // write-back of the registered product
  assign freq_acc = $signed({2'b00, freq_r, 16'h0000}) + $signed(prod_r[35:0]) + 36'sd32768;
  assign step_sum = {{(STEP_SUM_W - 44){1'b0}}, prod_r[43:0]} + STEP_ROUND;
  assign samp_sum = $signed(prod_r[32:0]) + 33'sd16384;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    freq_nxt   = freq_r;
    gain_nxt   = gain_r;
    sample_nxt = sample_r;
    case (ctrl.wb)
      WB_FREQ: begin
        freq_nxt = freq_acc[16 +: FREQ_W];
      end
      WB_GAIN: begin
        gain_nxt = prod_r[GAIN_RECIP_SHIFT +: GAIN_W];
      end
      WB_STEP: begin
        step_nxt = step_sum[STEP_SHIFT +: PHASE_BITS];
      end
      WB_SAMPLE: begin
        sample_nxt = samp_sum[15 +: SAMPLE_W];
        phase_nxt  = phase_r + step_r;
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      step_r      <= STEP_RESET;
      freq_r      <= FREQ_RESET;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      freq_r  <= freq_nxt;
      gain_r  <= gain_nxt;
      if (ctrl.wb == WB_SAMPLE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    if (accept) begin
      target_r <= target_nxt;
      gnum_r   <= gnum_nxt;
    end
    if (ctrl.mul != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
  end

  assign out_valid  = out_valid_r;
  assign sample_out = sample_r;

endmodule

`default_nettype wire

// File: hdl/biofeedback_sine_oscillator.sv
// Channel   Direction  Payload                              Request taken when
// in_ch     sink       action, heart_rate, hrv_level        in_ch.valid && in_ch.ready
// out_ch    source     sample_out (Q1.15)                   out_ch.valid && out_ch.ready
// cfg_*     write      cfg_index, cfg_wdata                 cfg_we
//
// Sample request: ROM read, multiply and output steps; the next request is taken after the output step.
// Update request: smoothing, frequency, gain and phase step run in turn and share one 27x23
// multiplier; an update taken while mapping is off ends after the smoothing step.
// Synchronous active-low reset restores configuration registers and oscillator state; no clearing pass.
// A full output register holds the sequencer on its output step until out_ch.ready.
`default_nettype none

module biofeedback_sine_oscillator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  bos_in_if.sink                               in_ch,
  bos_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [bos_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bos_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bos_pkg::*;

  logic                  mapping_enabled_r;
  logic [ALPHA_W-1:0]    alpha_r;
  logic [PER_HZ_W-1:0]   step_per_hz_r;

  logic                  in_ready;
  logic                  accept;
  ucode_t                ctrl;
  dp_status_t            status;
  logic                  out_free;
  logic [ROM_ADDR_W-1:0] rom_addr;
  logic [SINE_W-1:0]     rom_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapping_enabled_r <= 1'b1;
      alpha_r           <= ALPHA_RESET;
      step_per_hz_r     <= PER_HZ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAPPING_ENABLED: mapping_enabled_r <= cfg_wdata[0];
        CFG_SMOOTHING_ALPHA: alpha_r           <= cfg_wdata[ALPHA_W-1:0];
        CFG_STEP_PER_HZ:     step_per_hz_r     <= cfg_wdata[PER_HZ_W-1:0];
        default: begin
          alpha_r <= alpha_r;
        end
      endcase
    end
  end

  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign status      = '{mapping_enabled: mapping_enabled_r, out_free: out_free};

  bos_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .action (in_ch.action),
    .status (status),
    .ready  (in_ready),
    .ctrl   (ctrl)
  );

  bos_sine_rom u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  bos_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .accept      (accept),
    .heart_rate  (in_ch.heart_rate),
    .hrv_level   (in_ch.hrv_level),
    .alpha       (alpha_r),
    .step_per_hz (step_per_hz_r),
    .rom_data    (rom_data),
    .rom_addr    (rom_addr),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .sample_out  (out_ch.sample_out),
    .out_free    (out_free)
  );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
module tb_top;
  import bos_pkg::*;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [HR_W-1:0]     heart_rate;
    logic [HRV_W-1:0]    hrv_level;
  } osc_req_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  bos_in_if  in_if ();
  bos_out_if out_if ();

  biofeedback_sine_oscillator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // oscillator prediction state
  int                    sine_rom [0:QUARTER_LEN];
  logic [PHASE_BITS-1:0] osc_phase;
  logic [PHASE_BITS-1:0] osc_step;
  logic [FREQ_W-1:0]     osc_freq;
  logic [GAIN_W-1:0]     osc_gain;
  logic                  map_en;
  logic [ALPHA_W-1:0]    alpha;
  logic [PER_HZ_W-1:0]   per_hz;

  osc_req_t                   pending_reqs [$];
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  osc_req_t                   next_req;

  int mismatch_count = 0;
  int send_gap;
  int recv_stall;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_rx;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int quarter_entry(input int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned den;
    longint unsigned v;
    longint          acc;
    x    = (64'd1686629713 * i) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int k = 1; k <= 8; k++) begin
      den  = (2 * k) * (2 * k + 1);
      term = ((term * x2) >> 30) / den;
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = acc;
    v = (v * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  function automatic logic [PHASE_BITS-1:0] step_of(input logic [FREQ_W-1:0] freq,
                                                    input logic [PER_HZ_W-1:0] scale);
    longint unsigned p;
    longint unsigned s;
    p = freq;
    s = scale;
    p = (p * s + (64'd1 << (STEP_SHIFT - 1))) >> STEP_SHIFT;
    return p[PHASE_BITS-1:0];
  endfunction

  task automatic reset_osc();
    for (int i = 0; i <= QUARTER_LEN; i++) begin
      sine_rom[i] = quarter_entry(i);
    end
    map_en    = 1'b1;
    alpha     = 16'd6554;
    per_hz    = 26'd22906492;
    osc_phase = '0;
    osc_freq  = 18'd56320;
    osc_gain  = 16'd16384;
    osc_step  = step_of(osc_freq, per_hz);
  endtask

  task automatic retune_osc(input logic [HR_W-1:0] hr_in, input logic [HRV_W-1:0] hrv_in);
    longint unsigned hr;
    longint unsigned hv;
    longint unsigned target;
    longint unsigned fq;
    longint unsigned a;
    longint unsigned g;
    hr = hr_in;
    hv = hrv_in;
    if (hr < 640) begin
      hr = 640;
    end
    if (hr > 3200) begin
      hr = 3200;
    end
    target   = 25600 + 70 * (hr - 640);
    fq       = osc_freq;
    a        = alpha;
    fq       = (fq * (65536 - a) + target * a + 32768) >> 16;
    osc_freq = fq[FREQ_W-1:0];
    osc_step = step_of(osc_freq, per_hz);
    if (hv > 1600) begin
      hv = 1600;
    end
    g        = (256 * (1600 + 4 * hv) + 62) / 125;
    osc_gain = g[GAIN_W-1:0];
  endtask

  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    logic [SINE_TABLE_BITS+1:0] idx;
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-1:0] pos;
    longint                     s;
    longint                     g;
    longint                     r;
    idx  = osc_phase[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
    quad = idx[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
    pos  = idx[SINE_TABLE_BITS-1:0];
    if (quad[0]) begin
      s = sine_rom[QUARTER_LEN - int'(pos)];
    end else begin
      s = sine_rom[pos];
    end
    if (quad[1]) begin
      s = -s;
    end
    g = osc_gain;
    r = (s * g + 16384) >>> 15;
    osc_phase = osc_phase + osc_step;
    return r[SAMPLE_W-1:0];
  endfunction

  task automatic apply_request(input osc_req_t req);
    if (req.action == ACTION_SAMPLE) begin
      expected_samples.push_back(next_sample());
    end else if (map_en) begin
      retune_osc(req.heart_rate, req.hrv_level);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (!gaps_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic osc_req_t rand_req();
    osc_req_t r;
    r.action = ($urandom_range(0, 99) < 80) ? ACTION_SAMPLE : ACTION_UPDATE;
    if ($urandom_range(0, 3) == 0) begin
      r.heart_rate = HR_W'($urandom_range(0, 4095));
    end else begin
      r.heart_rate = HR_W'($urandom_range(560, 3300));
    end
    if ($urandom_range(0, 3) == 0) begin
      r.hrv_level = HRV_W'($urandom_range(0, 4095));
    end else begin
      r.hrv_level = HRV_W'($urandom_range(0, 1700));
    end
    return r;
  endfunction

  task automatic push_req(input logic [ACTION_W-1:0] action, input int hr, input int hrv);
    osc_req_t r;
    r.action     = action;
    r.heart_rate = HR_W'(hr);
    r.hrv_level  = HRV_W'(hrv);
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAPPING_ENABLED: map_en = val[0];
      CFG_SMOOTHING_ALPHA: alpha  = val[ALPHA_W-1:0];
      CFG_STEP_PER_HZ:     per_hz = val[PER_HZ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic en, input int a, input int scale);
    write_reg(CFG_MAPPING_ENABLED, CFG_DATA_W'(en));
    write_reg(CFG_SMOOTHING_ALPHA, CFG_DATA_W'(a));
    write_reg(CFG_STEP_PER_HZ, CFG_DATA_W'(scale));
  endtask

  // hold until every request is taken and every sample is back, then let updates finish
  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || expected_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_request('{action: in_if.action, heart_rate: in_if.heart_rate,
                        hrv_level: in_if.hrv_level});
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_if.valid      <= 1'b1;
          in_if.action     <= next_req.action;
          in_if.heart_rate <= next_req.heart_rate;
          in_if.hrv_level  <= next_req.hrv_level;
          send_gap = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample_out %0d", out_if.sample_out));
        end else if (out_if.sample_out !== expected_samples[0]) begin
          report_mismatch($sformatf("sample_out got %0d expected %0d",
                                    out_if.sample_out, expected_samples[0]));
          void'(expected_samples.pop_front());
        end else begin
          void'(expected_samples.pop_front());
        end
        recv_stall = pick_gap();
      end
      if (hold_rx || recv_stall > 0) begin
        out_if.ready <= 1'b0;
        if (recv_stall > 0) begin
          recv_stall--;
        end
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // long receiver stall so the output register fills and the input backs up
  initial begin
    hold_rx = 1'b0;
    wait (hold_req);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (200) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MAPPING_ENABLED;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.action     = ACTION_UPDATE;
    in_if.heart_rate = '0;
    in_if.hrv_level  = '0;
    out_if.ready     = 1'b0;
    reset_osc();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 7; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1: write_settings(1'b1, 65535, 67108863);
          2: write_settings(1'b1, 0, 1);
          3: write_settings(1'b0, 30000, 5000000);
          4: write_settings(1'b1, $urandom_range(0, 65535), 0);
          5: write_settings(1'b1, $urandom_range(0, 65535), $urandom_range(1, 67108863));
          default: write_settings(1'b1, 6554, 22906492);
        endcase
      end
      @(negedge clk);
      gaps_on = (p % 3) != 1;
      if (p == 0) begin
        repeat (3) push_req(ACTION_SAMPLE, 0, 0);
        push_req(ACTION_UPDATE, 0, 0);
        repeat (2) push_req(ACTION_SAMPLE, 0, 0);
        push_req(ACTION_UPDATE, 4095, 4095);
        repeat (2) push_req(ACTION_SAMPLE, 4095, 4095);
        push_req(ACTION_UPDATE, 640, 1600);
        push_req(ACTION_SAMPLE, 0, 0);
        push_req(ACTION_UPDATE, 3200, 1601);
        push_req(ACTION_SAMPLE, 0, 0);
        push_req(ACTION_UPDATE, 639, 1599);
        push_req(ACTION_SAMPLE, 0, 0);
        push_req(ACTION_UPDATE, 3201, 0);
        push_req(ACTION_SAMPLE, 4095, 4095);
        push_req(ACTION_UPDATE, 2730, 2730);
        push_req(ACTION_UPDATE, 1365, 1365);
        push_req(ACTION_SAMPLE, 2730, 1365);
      end
      if (p == 3) begin
        push_req(ACTION_UPDATE, 3200, 0);
        push_req(ACTION_SAMPLE, 0, 0);
      end
      repeat (145) pending_reqs.push_back(rand_req());
      if (p == 4) begin
        hold_req = 1'b1;
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/bos_pkg.sv
hdl/bos_ifs.sv
hdl/bos_sine_rom.sv
hdl/bos_sequencer.sv
hdl/bos_datapath.sv
hdl/biofeedback_sine_oscillator.sv
sim/tb_top.sv
